// ===== hw/rtl/cxd_pkg.sv =====
// cxd_pkg: shared constants and controller/datapath interface types
// for the 3x3 rgb convolution block; no dependencies
`timescale 1ns / 1ps
package cxd_pkg;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int COEFF_BITS   = 8;
    localparam int PIX_W        = 24;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int DIM_W        = 11;
    localparam int POS_W        = 10;
    localparam int OWED_W       = 11;
    localparam int CFG_W        = 3 * COEFF_BITS;
    localparam int CFG_IDX_W    = 3;
    localparam int TAPS         = 9;
    localparam int TAP_W        = 4;
    // 8-bit unsigned channel times signed coefficient, nine taps, one extra bit
    localparam int ACC_W        = 8 + 1 + COEFF_BITS + 4;
    localparam int DIV_STEPS    = ACC_W - 1;
    localparam int CNT_W        = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERN_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

    localparam logic ACT_PIXEL = 1'b0;

    typedef struct packed {
        logic             accept;
        logic             rd_pix;
        logic             wr_pix;
        logic             take_pass;
        logic             drain_rd;
        logic             drain_take;
        logic             tap_en;
        logic [TAP_W-1:0] tap;
        logic             drop_step;
        logic             div_start;
        logic             div_step;
        logic             div_fin;
        logic             load_out;
    } cxd_cmd_t;

    typedef struct packed {
        logic in_action;
        logic owed_zero;
        logic emit;
        logic interior;
        logic out_free;
    } cxd_sts_t;
endpackage

// ===== hw/rtl/cxd_ctrl.sv =====
// cxd_ctrl: sequencer for pixel, drain, filter and divide steps
// depends on cxd_pkg
`timescale 1ns / 1ps
module cxd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cxd_pkg::cxd_sts_t sts,
    output cxd_pkg::cxd_cmd_t cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_PRD, ST_PWR, ST_PASS, ST_FILT, ST_DROP,
        ST_DIV, ST_FIN, ST_DRD, ST_DDATA, ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [cxd_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.tap    = cnt_reg[cxd_pkg::TAP_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = (sts.in_action == cxd_pkg::ACT_PIXEL) ? ST_PRD : ST_DRD;
                end
            end
            ST_PRD: begin
                cmd.rd_pix = 1'b1;
                state_next = ST_PWR;
            end
            ST_PWR: begin
                cmd.wr_pix = 1'b1;
                state_next = ST_PASS;
            end
            ST_PASS: begin
                cmd.take_pass = 1'b1;
                cnt_next      = '0;
                if (!sts.emit) state_next = ST_IDLE;
                else if (sts.interior) state_next = ST_FILT;
                else state_next = ST_OUT;
            end
            ST_FILT: begin
                cmd.tap_en = 1'b1;
                if (cnt_reg == cxd_pkg::CNT_W'(cxd_pkg::TAPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DROP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DROP: begin
                cmd.drop_step = 1'b1;
                state_next    = ST_DIV;
                cmd.div_start = 1'b0;
            end
            ST_DIV: begin
                if (cnt_reg == '0) cmd.div_start = 1'b1;
                else cmd.div_step = 1'b1;
                if (cnt_reg == cxd_pkg::CNT_W'(cxd_pkg::DIV_STEPS)) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.div_fin = 1'b1;
                state_next  = ST_OUT;
            end
            ST_DRD: begin
                if (sts.owed_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.drain_rd = 1'b1;
                    state_next   = ST_DDATA;
                end
            end
            ST_DDATA: begin
                cmd.drain_take = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILT |-> cnt_reg < cxd_pkg::CNT_W'(cxd_pkg::TAPS))
        else $error("tap counter past last tap");
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg <= cxd_pkg::CNT_W'(cxd_pkg::DIV_STEPS))
        else $error("divide counter overrun");
endmodule

// ===== hw/rtl/cxd_dp.sv =====
// cxd_dp: config registers, line stores, 3x3 window, tap mac, divider, output register
// depends on cxd_pkg
`timescale 1ns / 1ps
module cxd_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cxd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [cxd_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                in_action,
    input  logic [cxd_pkg::PIX_W-1:0]           in_pix,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [cxd_pkg::PIX_W-1:0]           m_pix,
    output logic                                m_last,
    input  cxd_pkg::cxd_cmd_t                   cmd,
    output cxd_pkg::cxd_sts_t                   sts
);
    localparam int AW = cxd_pkg::ADDR_W;
    localparam int DW = cxd_pkg::DIM_W;
    localparam int PW = cxd_pkg::POS_W;
    localparam int OW = cxd_pkg::OWED_W;
    localparam int CB = cxd_pkg::COEFF_BITS;
    localparam int AC = cxd_pkg::ACC_W;
    localparam int QW = cxd_pkg::DIV_STEPS;

    logic [cxd_pkg::CFG_W-1:0] kern_reg [3];
    logic [7:0]                scale_reg;
    logic                      drop_reg;
    logic [DW-1:0]             width_reg, height_reg;
    logic [DW-1:0]             dim_clamp, dim_max;
    logic [PW-1:0]             col_reg, row_reg;
    logic [OW-1:0]             owed_reg;

    logic [cxd_pkg::PIX_W-1:0] upper_mem [cxd_pkg::MAX_WIDTH];
    logic [cxd_pkg::PIX_W-1:0] lower_mem [cxd_pkg::MAX_WIDTH];
    logic [cxd_pkg::PIX_W-1:0] up_rd_reg, lo_rd_reg;
    logic [AW-1:0]             up_addr, lo_addr;

    logic [cxd_pkg::PIX_W-1:0] pix_reg, res_reg;
    logic                      act_reg, emit_reg, inter_reg, eof_reg, res_eof_reg;
    logic                      dsel_up_reg;
    logic [cxd_pkg::PIX_W-1:0] win_reg [cxd_pkg::TAPS];

    // position helpers
    logic [AW-1:0] col_m1;
    logic [DW-1:0] w_p1, drain_d;
    logic [DW:0]   drain_t;
    logic [AW-1:0] drain_addr;
    logic          drain_eof;
    logic [DW-1:0] ocol, orow;
    logic          pix_emit, pix_inter, pix_eof;
    logic [DW-1:0] col_ext, row_ext;

    assign col_ext = DW'(col_reg);
    assign row_ext = DW'(row_reg);

    always_comb begin
        dim_max   = (cfg_addr == cxd_pkg::REG_HEIGHT) ? DW'(cxd_pkg::HEIGHT_LIMIT) :
                                                        DW'(cxd_pkg::MAX_WIDTH);
        dim_clamp = cfg_wdata[DW-1:0];
        if (dim_clamp < DW'(3)) dim_clamp = DW'(3);
        if (dim_clamp > dim_max) dim_clamp = dim_max;
    end

    always_comb begin
        col_m1     = (col_reg == '0) ? AW'(width_reg - 1'b1) : AW'(col_reg - 1'b1);
        w_p1       = width_reg + 1'b1;
        drain_d    = (DW'(owed_reg) > w_p1) ? w_p1 : DW'(owed_reg);
        drain_t    = {1'b0, col_ext} + {1'b0, width_reg} - {1'b0, drain_d};
        if (drain_t >= {1'b0, width_reg}) drain_t = drain_t - {1'b0, width_reg};
        drain_addr = AW'(drain_t);
        // last pixel of frame lies drain_d steps back
        drain_eof  = ((drain_d == col_ext + 1'b1) && row_reg == '0) ||
                     (col_reg == '0 && drain_d == w_p1 && row_reg == PW'(1));
        pix_emit   = (DW'(owed_reg) >= w_p1);
        if (col_reg != '0) begin
            ocol = col_ext - 1'b1;
            orow = (row_reg != '0) ? row_ext - 1'b1 : height_reg - 1'b1;
        end else begin
            ocol = width_reg - 1'b1;
            orow = (row_reg >= PW'(2)) ? row_ext - DW'(2) : row_ext + height_reg - DW'(2);
        end
        pix_inter  = (orow >= DW'(1)) && (orow + DW'(2) <= height_reg) &&
                     (ocol >= DW'(1)) && (ocol + DW'(2) <= width_reg);
        pix_eof    = (col_reg == '0) && (row_reg == PW'(1));
    end

    // config registers and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kern_reg[0] <= '0;
            kern_reg[1] <= cxd_pkg::CFG_W'(256);
            kern_reg[2] <= '0;
            scale_reg   <= 8'd1;
            drop_reg    <= 1'b0;
            width_reg   <= DW'(cxd_pkg::MAX_WIDTH);
            height_reg  <= DW'(cxd_pkg::HEIGHT_LIMIT);
            col_reg     <= '0;
            row_reg     <= '0;
            owed_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cxd_pkg::REG_KERN_TOP: kern_reg[0] <= cfg_wdata;
                cxd_pkg::REG_KERN_MID: kern_reg[1] <= cfg_wdata;
                cxd_pkg::REG_KERN_BOT: kern_reg[2] <= cfg_wdata;
                cxd_pkg::REG_SCALE:    scale_reg   <= cfg_wdata[7:0];
                cxd_pkg::REG_DROP:     drop_reg    <= cfg_wdata[0];
                cxd_pkg::REG_WIDTH: begin
                    width_reg <= dim_clamp;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    owed_reg  <= '0;
                end
                cxd_pkg::REG_HEIGHT: begin
                    height_reg <= dim_clamp;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    owed_reg   <= '0;
                end
                default: ;
            endcase
        end else if (cmd.wr_pix) begin
            owed_reg <= emit_reg ? OW'(w_p1) : owed_reg + 1'b1;
            if (col_ext + 1'b1 >= width_reg) begin
                col_reg <= '0;
                row_reg <= (row_ext + 1'b1 >= height_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end else if (cmd.drain_rd) begin
            owed_reg <= OW'(drain_d - 1'b1);
        end
    end

    // line stores: one write and one registered read each per cycle
    always_comb begin
        up_addr = cmd.rd_pix ? AW'(col_reg) : col_m1;
        lo_addr = cmd.rd_pix ? AW'(col_reg) : drain_addr;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_pix) begin
            upper_mem[AW'(col_reg)] <= lo_rd_reg;
            lower_mem[AW'(col_reg)] <= pix_reg;
        end
        up_rd_reg <= upper_mem[up_addr];
        lo_rd_reg <= lower_mem[lo_addr];
    end

    // item capture, window and result selection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cxd_pkg::TAPS; i++) win_reg[i] <= '0;
        end else if (cmd.wr_pix) begin
            for (int rr = 0; rr < 3; rr++) begin
                win_reg[rr*3]   <= win_reg[rr*3+1];
                win_reg[rr*3+1] <= win_reg[rr*3+2];
            end
            win_reg[2] <= up_rd_reg;
            win_reg[5] <= lo_rd_reg;
            win_reg[8] <= pix_reg;
        end
    end

    logic [7:0] q_clamp [3];

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg <= in_action;
            pix_reg <= in_pix;
        end
        if (cmd.rd_pix) begin
            emit_reg  <= pix_emit;
            inter_reg <= pix_inter;
            eof_reg   <= pix_eof;
        end
        if (cmd.drain_rd) begin
            dsel_up_reg <= (drain_d == w_p1);
            eof_reg     <= drain_eof;
        end
        if (cmd.take_pass) begin
            res_reg     <= up_rd_reg;
            res_eof_reg <= eof_reg;
        end
        if (cmd.drain_take) begin
            res_reg     <= dsel_up_reg ? up_rd_reg : lo_rd_reg;
            res_eof_reg <= eof_reg;
        end
        if (cmd.div_fin) res_reg <= {q_clamp[0], q_clamp[1], q_clamp[2]};
    end

    // one tap per cycle, three channel multipliers
    logic signed [CB-1:0] coef [cxd_pkg::TAPS];
    logic signed [CB-1:0] tap_coef;
    logic [cxd_pkg::PIX_W-1:0] tap_pix, lo_pix, hi_pix;
    logic signed [AC-1:0] acc_reg [3];
    logic signed [8+CB:0] prod [3];
    logic [9:0]           inten, lo_reg, hi_reg;
    logic [cxd_pkg::TAP_W-1:0] ilo_reg, ihi_reg;

    always_comb begin
        for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++)
                coef[rr*3+cc] = kern_reg[rr][cc*CB +: CB];
        tap_coef = coef[cmd.tap];
        tap_pix  = win_reg[cmd.tap];
        lo_pix   = win_reg[ilo_reg];
        hi_pix   = win_reg[ihi_reg];
        for (int k = 0; k < 3; k++)
            prod[k] = $signed({1'b0, tap_pix[16-8*k +: 8]}) * tap_coef;
        inten = 10'(tap_pix[23:16]) + 10'(tap_pix[15:8]) + 10'(tap_pix[7:0]);
    end

    // restoring divider, one quotient bit per step per channel
    logic [QW-1:0] dvd_reg [3];
    logic [7:0]    rem_reg [3];
    logic [8:0]    rem_sh  [3];
    logic [7:0]    divisor;

    assign divisor = (scale_reg == '0) ? 8'd1 : scale_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_sh[k]  = {rem_reg[k], dvd_reg[k][QW-1]};
            q_clamp[k] = (dvd_reg[k] > QW'(255)) ? 8'd255 : dvd_reg[k][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tap_en) begin
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= (cmd.tap == '0) ? AC'(prod[k]) : acc_reg[k] + AC'(prod[k]);
            if (cmd.tap == '0 || inten <= lo_reg) begin
                lo_reg  <= inten;
                ilo_reg <= cmd.tap;
            end
            if (cmd.tap == '0 || inten > hi_reg) begin
                hi_reg  <= inten;
                ihi_reg <= cmd.tap;
            end
        end
        if (cmd.drop_step && drop_reg) begin
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= acc_reg[k] - AC'({1'b0, lo_pix[16-8*k +: 8]})
                                         - AC'({1'b0, hi_pix[16-8*k +: 8]});
        end
        if (cmd.div_start) begin
            for (int k = 0; k < 3; k++) begin
                // a negative or zero sum clamps to zero
                dvd_reg[k] <= acc_reg[k][AC-1] ? '0 : acc_reg[k][QW-1:0];
                rem_reg[k] <= '0;
            end
        end
        if (cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                if (rem_sh[k] >= {1'b0, divisor}) begin
                    rem_reg[k] <= 8'(rem_sh[k] - {1'b0, divisor});
                    dvd_reg[k] <= {dvd_reg[k][QW-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= rem_sh[k][7:0];
                    dvd_reg[k] <= {dvd_reg[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    logic m_valid_reg;
    logic out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_pix  <= res_reg;
            m_last <= res_eof_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb begin
        sts           = '0;
        sts.in_action = in_action;
        sts.owed_zero = (owed_reg == '0);
        sts.emit      = emit_reg && (act_reg == cxd_pkg::ACT_PIXEL);
        sts.interior  = inter_reg;
        sts.out_free  = out_free;
    end

    a_owed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        DW'(owed_reg) <= width_reg + 1'b1)
        else $error("owed count above width plus one");
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_ext < width_reg)
        else $error("column outside row");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result loaded over a pending transaction");
endmodule

// ===== hw/rtl/conv3x3_rgb_extreme_drop.sv =====
// conv3x3_rgb_extreme_drop: top level of the streaming 3x3 rgb filter
// depends on cxd_pkg, cxd_ctrl, cxd_dp
//
// channel   direction  payload
// s_        in         tuser: action; tdata: red, green, blue
// m_        out        tdata: out_red, out_green, out_blue; tlast: end_of_frame
// cfg_      in         register index and write data, no handshake
//
// one item at a time: a pixel is read, written and passed; a border result
// then loads the output, a filtered one runs nine taps, drop, divide and finish
// first; a drain tick reads and loads only if owed; loads wait on any m_ stall
// tap mac and bit-serial divider set the rate
// synchronous active-low reset; line stores are not cleared
// s_tready is high only between items; a stalled m_ side holds the next result
`timescale 1ns / 1ps
module conv3x3_rgb_extreme_drop (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red, green, blue
    input  logic                              s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // out_red, out_green, out_blue
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cxd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cxd_pkg::CFG_W-1:0]         cfg_wdata
);
    cxd_pkg::cxd_cmd_t cmd;
    cxd_pkg::cxd_sts_t sts;
    logic [23:0]       m_pix;
    logic [23:0]       in_pix;

    // internal pixel word keeps red in the low byte
    assign in_pix  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign m_tdata = {m_pix[7:0], m_pix[15:8], m_pix[23:16]};

    cxd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cxd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_pix    (in_pix),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_pix     (m_pix),
        .m_last    (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
